[rtl/cpcc_pkg.sv]
// ----------------------------------------------------------------------------
// cpcc_pkg
// Shared types and constants for the color point core classifier.
// ----------------------------------------------------------------------------
package cpcc_pkg;

  localparam int MAX_POINTS_DEFAULT = 256;

  localparam logic [17:0] RADIUS_SQ_RESET  = 18'd25;
  localparam logic [8:0]  MIN_POINTS_RESET = 9'd10;
  localparam logic [8:0]  COUNT_MAX        = 9'd511;

  // Command codes
  localparam logic [1:0] CMD_STORE    = 2'd0;
  localparam logic [1:0] CMD_CLASSIFY = 2'd1;
  localparam logic [1:0] CMD_CLEAR    = 2'd2;

  // Status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  // Label codes
  localparam logic [1:0] LABEL_UNDEFINED = 2'd0;
  localparam logic [1:0] LABEL_CORE      = 2'd1;
  localparam logic [1:0] LABEL_OUTLIER   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_RADIUS_SQ  = 1'b0;
  localparam logic CFG_MIN_POINTS = 1'b1;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } point_t;

  typedef struct packed {
    logic [1:0] label;
    point_t     point;
  } entry_t;

  // Status of the distance unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic hit_valid;
    logic hit;
  } dist_status_t;

endpackage

[rtl/cpcc_mem.sv]
// ----------------------------------------------------------------------------
// cpcc_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cpcc_mem #(
  parameter int DEPTH = cpcc_pkg::MAX_POINTS_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  cpcc_pkg::entry_t   wdata,
  input  logic [AW-1:0]      raddr,
  output cpcc_pkg::entry_t   rdata
);

  cpcc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/cpcc_dist.sv]
// ----------------------------------------------------------------------------
// cpcc_dist
// Pipelined squared color distance and radius compare, one pair per cycle.
// ----------------------------------------------------------------------------
module cpcc_dist (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  cpcc_pkg::point_t        a,
  input  cpcc_pkg::point_t        b,
  input  logic [17:0]             radius_squared,
  output cpcc_pkg::dist_status_t  status
);

  logic        v1, v2, v3;
  logic [7:0]  dh, ds, db;
  logic [15:0] qh, qs, qb;
  logic        hit;

  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
    abs_diff = (x > y) ? (x - y) : (y - x);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
    dh  <= abs_diff(a.hue, b.hue);
    ds  <= abs_diff(a.saturation, b.saturation);
    db  <= abs_diff(a.brightness, b.brightness);
    qh  <= dh * dh;
    qs  <= ds * ds;
    qb  <= db * db;
    hit <= (18'(qh) + 18'(qs) + 18'(qb)) <= radius_squared;
  end

  assign status.busy      = v1 | v2 | v3;
  assign status.hit_valid = v3;
  assign status.hit       = hit;

endmodule

[rtl/color_point_core_classifier_unit.sv]
// ----------------------------------------------------------------------------
// color_point_core_classifier_unit
// Store of HSV color points with a DBSCAN style core point test.
// ----------------------------------------------------------------------------
// Store, clear and unused commands pass from acceptance through the done
// state to the output register. A classify of a stored but unlabelled entry
// reads that entry, then streams every stored point through one pipelined
// distance unit, one point a cycle from the single read port of the entry
// store; a bad index goes straight to the done state, and an already
// labelled entry goes to it from the lookup. One transaction is worked on
// at a time; in_stall is high while it is in progress, and a new transaction
// is taken as soon as the result has moved to the output register. The
// store needs no clearing after reset: only entries below the fill count are ever read.
// ----------------------------------------------------------------------------
module color_point_core_classifier_unit #(
  parameter int MAX_POINTS = cpcc_pkg::MAX_POINTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [7:0]  hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  input  logic [7:0]  point_index,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  label,
  output logic [8:0]  neighbor_count,
  output logic [8:0]  stored_count,
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [17:0] cfg_data
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int XW = (CW > 8) ? CW : 8;
  localparam int SW = (CW > 9) ? CW : 9;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOKUP, S_SWEEP, S_DRAIN, S_FINISH, S_DONE
  } state_t;

  state_t                  state;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           sweep_idx;
  logic [CW-1:0]           cnt;
  logic [AW-1:0]           cur_idx;
  cpcc_pkg::point_t        me;
  logic                    rd_pending;
  logic [17:0]             radius_squared;
  logic [8:0]              min_points;
  logic [1:0]              res_status;
  logic [1:0]              res_label;
  logic [8:0]              res_count;

  logic                    in_accept;
  logic                    full;
  logic                    bad_index;
  logic [XW-1:0]           idx_x;
  logic [AW-1:0]           idx_addr;
  logic [SW-1:0]           fill_s;
  logic [SW-1:0]           cnt_s;
  logic [8:0]              fill_sat;
  logic [8:0]              cnt_sat;
  logic [1:0]              new_label;
  logic [CW-1:0]           sweep_idx_next;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  cpcc_pkg::entry_t        mem_wdata;
  logic [AW-1:0]           mem_raddr;
  cpcc_pkg::entry_t        mem_rdata;
  cpcc_pkg::dist_status_t  dunit;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign full      = (fill == CW'(MAX_POINTS));
  assign idx_x     = XW'(point_index);
  assign bad_index = (idx_x >= XW'(fill));
  assign idx_addr  = idx_x[AW-1:0];

  assign fill_s   = SW'(fill);
  assign cnt_s    = SW'(cnt);
  assign fill_sat = (fill_s > SW'(cpcc_pkg::COUNT_MAX)) ? cpcc_pkg::COUNT_MAX : fill_s[8:0];
  assign cnt_sat  = (cnt_s > SW'(cpcc_pkg::COUNT_MAX)) ? cpcc_pkg::COUNT_MAX : cnt_s[8:0];
  assign new_label = (cnt_s > SW'(min_points)) ? cpcc_pkg::LABEL_CORE
                                               : cpcc_pkg::LABEL_OUTLIER;
  assign sweep_idx_next = sweep_idx + CW'(1);

  // Store port: append on a store transaction, write back the label on finish
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill[AW-1:0];
    mem_wdata.label            = cpcc_pkg::LABEL_UNDEFINED;
    mem_wdata.point.hue        = hue;
    mem_wdata.point.saturation = saturation;
    mem_wdata.point.brightness = brightness;
    if (state == S_FINISH) begin
      mem_we          = 1'b1;
      mem_waddr       = cur_idx;
      mem_wdata.label = new_label;
      mem_wdata.point = me;
    end else if (in_accept && command == cpcc_pkg::CMD_STORE && !full) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = (state == S_SWEEP) ? sweep_idx[AW-1:0] : idx_addr;

  cpcc_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cpcc_dist u_dist (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (rd_pending),
    .a              (mem_rdata.point),
    .b              (me),
    .radius_squared (radius_squared),
    .status         (dunit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      fill           <= '0;
      rd_pending     <= 1'b0;
      out_valid      <= 1'b0;
      radius_squared <= cpcc_pkg::RADIUS_SQ_RESET;
      min_points     <= cpcc_pkg::MIN_POINTS_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          cpcc_pkg::CFG_RADIUS_SQ:  radius_squared <= cfg_data;
          cpcc_pkg::CFG_MIN_POINTS: min_points     <= cfg_data[8:0];
          default: ;
        endcase
      end

      rd_pending <= (state == S_SWEEP);
      if (dunit.hit_valid && dunit.hit) begin
        cnt <= cnt + CW'(1);
      end

      // Drop the result once it has been taken
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_label <= cpcc_pkg::LABEL_UNDEFINED;
            res_count <= '0;
            case (command)
              cpcc_pkg::CMD_STORE: begin
                state <= S_DONE;
                if (full) begin
                  res_status <= cpcc_pkg::STATUS_FULL;
                end else begin
                  res_status <= cpcc_pkg::STATUS_OK;
                  fill       <= fill + CW'(1);
                end
              end
              cpcc_pkg::CMD_CLASSIFY: begin
                if (bad_index) begin
                  res_status <= cpcc_pkg::STATUS_BAD_INDEX;
                  state      <= S_DONE;
                end else begin
                  res_status <= cpcc_pkg::STATUS_OK;
                  cur_idx    <= idx_addr;
                  state      <= S_LOOKUP;
                end
              end
              cpcc_pkg::CMD_CLEAR: begin
                res_status <= cpcc_pkg::STATUS_OK;
                fill       <= '0;
                state      <= S_DONE;
              end
              default: begin
                res_status <= cpcc_pkg::STATUS_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_LOOKUP: begin
          me <= mem_rdata.point;
          if (mem_rdata.label != cpcc_pkg::LABEL_UNDEFINED) begin
            res_label <= mem_rdata.label;
            state     <= S_DONE;
          end else begin
            sweep_idx <= '0;
            cnt       <= '0;
            state     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          // Issue one stored entry per cycle
          sweep_idx <= sweep_idx_next;
          if (sweep_idx_next == fill) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_pending && !dunit.busy) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          res_label <= new_label;
          res_count <= cnt_sat;
          state     <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            label          <= res_label;
            neighbor_count <= res_count;
            stored_count   <= fill_sat;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
